### rtl/core/bffla_pkg.sv
`timescale 1ns / 1ps
// bffla_pkg: shared types and constants of the best-fit free-list allocator
// used by the controller, the datapath and the top level; depends on nothing

package bffla_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned WORD_BYTES = 4;
   localparam int unsigned NODE_BYTES = 8;
   localparam int unsigned HDR_BYTES  = 8;
   localparam int unsigned AMOUNT_W   = 17;
   localparam int unsigned LOC_W      = 16;
   localparam int unsigned FREE_W     = 17;

   // datapath micro-operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE, OP_CLR, OP_INIT0, OP_INIT1, OP_INIT2, OP_LOAD,
      OP_ASTART, OP_ARS, OP_ARN, OP_AEV, OP_AEND, OP_ASPL1, OP_ASPL2,
      OP_ALINK, OP_AHDR,
      OP_FSTART, OP_FSIZE, OP_FWALK, OP_FWN, OP_FPREV, OP_FPCHK, OP_FCUR,
      OP_FN1, OP_FN2, OP_FM1, OP_FM2, OP_FB1, OP_FB2, OP_FB3,
      OP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      ok;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_free;
      logic a_empty;
      logic a_more;
      logic a_found;
      logic a_split;
      logic f_hdr_bad;
      logic f_size_bad;
      logic f_walk_go;
      logic f_wn_stop;
      logic f_has_prev;
      logic f_prev_bad;
      logic f_cur_bad;
      logic f_cur_merge;
      logic f_prev_merge;
   } dp_stat_type;

endpackage

### rtl/core/bffla_ram.sv
`timescale 1ns / 1ps
// bffla_ram: generic single write port ram with registered read
// no dependencies

module bffla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bffla_ctrl.sv
`timescale 1ns / 1ps
// bffla_ctrl: sequencing state machine of the allocator
// depends on bffla_pkg for the command and status types

module bffla_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bffla_pkg::dp_stat_type stat,
   output bffla_pkg::dp_cmd_type  cmd
);

   typedef enum logic [28:0] {
      S_CLR   = 29'b1 << 0,
      S_I0    = 29'b1 << 1,
      S_I1    = 29'b1 << 2,
      S_I2    = 29'b1 << 3,
      S_IDLE  = 29'b1 << 4,
      S_AST   = 29'b1 << 5,
      S_ARS   = 29'b1 << 6,
      S_ARN   = 29'b1 << 7,
      S_AEV   = 29'b1 << 8,
      S_AEND  = 29'b1 << 9,
      S_ASP1  = 29'b1 << 10,
      S_ASP2  = 29'b1 << 11,
      S_ALNK  = 29'b1 << 12,
      S_AHDR  = 29'b1 << 13,
      S_FST   = 29'b1 << 14,
      S_FSZ   = 29'b1 << 15,
      S_FW    = 29'b1 << 16,
      S_FWN   = 29'b1 << 17,
      S_FP    = 29'b1 << 18,
      S_FPC   = 29'b1 << 19,
      S_FC    = 29'b1 << 20,
      S_FN1   = 29'b1 << 21,
      S_FN2   = 29'b1 << 22,
      S_FM    = 29'b1 << 23,
      S_FM2   = 29'b1 << 24,
      S_FB2   = 29'b1 << 25,
      S_FB3   = 29'b1 << 26,
      S_ROK   = 29'b1 << 27,
      S_RFAIL = 29'b1 << 28
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = bffla_pkg::OP_NONE;
      cmd.ok   = 1'b0;
      busy     = 1'b1;
      case (state_ff)
         S_CLR: begin
            cmd.op = bffla_pkg::OP_CLR;
            if (stat.clr_last) state_in = S_I0;
         end
         S_I0: begin
            cmd.op   = bffla_pkg::OP_INIT0;
            state_in = S_I1;
         end
         S_I1: begin
            cmd.op   = bffla_pkg::OP_INIT1;
            state_in = S_I2;
         end
         S_I2: begin
            cmd.op   = bffla_pkg::OP_INIT2;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.op   = bffla_pkg::OP_LOAD;
               state_in = stat.req_free ? S_FST : S_AST;
            end
         end
         S_AST: begin
            cmd.op   = bffla_pkg::OP_ASTART;
            state_in = stat.a_empty ? S_RFAIL : S_ARS;
         end
         S_ARS: begin
            cmd.op   = bffla_pkg::OP_ARS;
            state_in = S_ARN;
         end
         S_ARN: begin
            cmd.op   = bffla_pkg::OP_ARN;
            state_in = S_AEV;
         end
         S_AEV: begin
            cmd.op   = bffla_pkg::OP_AEV;
            state_in = stat.a_more ? S_ARS : S_AEND;
         end
         S_AEND: begin
            cmd.op = bffla_pkg::OP_AEND;
            if (!stat.a_found) state_in = S_RFAIL;
            else state_in = stat.a_split ? S_ASP1 : S_ALNK;
         end
         S_ASP1: begin
            cmd.op   = bffla_pkg::OP_ASPL1;
            state_in = S_ASP2;
         end
         S_ASP2: begin
            cmd.op   = bffla_pkg::OP_ASPL2;
            state_in = S_ALNK;
         end
         S_ALNK: begin
            cmd.op   = bffla_pkg::OP_ALINK;
            state_in = S_AHDR;
         end
         S_AHDR: begin
            cmd.op   = bffla_pkg::OP_AHDR;
            state_in = S_ROK;
         end
         S_FST: begin
            cmd.op   = bffla_pkg::OP_FSTART;
            state_in = stat.f_hdr_bad ? S_RFAIL : S_FSZ;
         end
         S_FSZ: begin
            cmd.op   = bffla_pkg::OP_FSIZE;
            state_in = stat.f_size_bad ? S_RFAIL : S_FW;
         end
         S_FW: begin
            cmd.op   = bffla_pkg::OP_FWALK;
            state_in = stat.f_walk_go ? S_FWN : S_FP;
         end
         S_FWN: begin
            cmd.op   = bffla_pkg::OP_FWN;
            state_in = stat.f_wn_stop ? S_FP : S_FW;
         end
         S_FP: begin
            cmd.op   = bffla_pkg::OP_FPREV;
            state_in = stat.f_has_prev ? S_FPC : S_FC;
         end
         S_FPC: begin
            cmd.op   = bffla_pkg::OP_FPCHK;
            state_in = stat.f_prev_bad ? S_RFAIL : S_FC;
         end
         S_FC: begin
            cmd.op = bffla_pkg::OP_FCUR;
            if (stat.f_cur_bad) state_in = S_RFAIL;
            else state_in = stat.f_cur_merge ? S_FN1 : S_FM;
         end
         S_FN1: begin
            cmd.op   = bffla_pkg::OP_FN1;
            state_in = S_FN2;
         end
         S_FN2: begin
            cmd.op   = bffla_pkg::OP_FN2;
            state_in = S_FM;
         end
         S_FM: begin
            if (stat.f_prev_merge) begin
               cmd.op   = bffla_pkg::OP_FM1;
               state_in = S_FM2;
            end else begin
               cmd.op   = bffla_pkg::OP_FB1;
               state_in = S_FB2;
            end
         end
         S_FM2: begin
            cmd.op   = bffla_pkg::OP_FM2;
            state_in = S_ROK;
         end
         S_FB2: begin
            cmd.op   = bffla_pkg::OP_FB2;
            state_in = S_FB3;
         end
         S_FB3: begin
            cmd.op   = bffla_pkg::OP_FB3;
            state_in = S_ROK;
         end
         S_ROK: begin
            cmd.op   = bffla_pkg::OP_RESP;
            cmd.ok   = 1'b1;
            state_in = S_IDLE;
         end
         S_RFAIL: begin
            cmd.op   = bffla_pkg::OP_RESP;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/bffla_dp.sv
`timescale 1ns / 1ps
// bffla_dp: list registers, byte-lane arena memory and result registers
// depends on bffla_pkg and bffla_ram

module bffla_dp #(
   parameter int ARENA_BYTES = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bffla_pkg::dp_cmd_type               cmd,
   output bffla_pkg::dp_stat_type              stat,
   input  logic                                req_opcode,
   input  logic [bffla_pkg::AMOUNT_W-1:0]      req_amount,
   input  logic [bffla_pkg::LOC_W-1:0]         req_location,
   output logic                                rsp_strobe,
   output logic                                rsp_ok,
   output logic [bffla_pkg::LOC_W-1:0]         rsp_granted_offset,
   output logic [bffla_pkg::FREE_W-1:0]        rsp_free_bytes
);

   localparam int DEPTH = (ARENA_BYTES + 3) / 4;
   localparam int RW    = $clog2(DEPTH);
   localparam int DW    = bffla_pkg::DATA_W;
   localparam logic [DW-1:0] ARENA_W = DW'(ARENA_BYTES);
   localparam logic [DW-1:0] LAST_W  = DW'(ARENA_BYTES - 4);
   localparam logic [DW-1:0] WORD_W  = DW'(bffla_pkg::WORD_BYTES);
   localparam logic [DW-1:0] NODE_W  = DW'(bffla_pkg::NODE_BYTES);
   localparam logic [DW-1:0] HDR_W   = DW'(bffla_pkg::HDR_BYTES);

   logic [DW-1:0] head_ff, head_in, total_ff, total_in;
   logic [bffla_pkg::AMOUNT_W-1:0] amount_ff, amount_in;
   logic [bffla_pkg::LOC_W-1:0]    location_ff, location_in;
   logic [DW-1:0] req_ff, req_in, cur_ff, cur_in, prev_ff, prev_in;
   logic [DW-1:0] best_ff, best_in, bestprev_ff, bestprev_in;
   logic [DW-1:0] bestsz_ff, bestsz_in, bestnext_ff, bestnext_in;
   logic          found_ff, found_in;
   logic [DW-1:0] sz_ff, sz_in, blk_ff, blk_in, end_ff, end_in, psz_ff, psz_in;
   logic [DW-1:0] nsz_ff, nsz_in, nnext_ff, nnext_in, link_ff, link_in;
   logic [bffla_pkg::LOC_W-1:0] grant_ff, grant_in;
   logic [RW:0]   clr_cnt_ff, clr_cnt_in;
   logic          rsp_strobe_ff, rsp_ok_ff;
   logic [bffla_pkg::LOC_W-1:0]  rsp_grant_ff;
   logic [bffla_pkg::FREE_W-1:0] rsp_free_ff;

   logic [DW-1:0] rd_addr, wr_addr, wr_data, rd_data;
   logic          wr_req, clr_en;
   logic [1:0]    rd_lane_ff;
   logic          rd_oob_ff;
   logic [DW-1:0] amt4, blk_calc, rest, grant_full;
   logic [7:0]    bank_q [4];

   assign amt4       = DW'(amount_ff) + WORD_W;
   assign blk_calc   = DW'(location_ff) + WORD_W;
   assign rest       = bestsz_ff - req_ff;
   assign grant_full = best_ff + WORD_W - HDR_W;

   // status toward the controller
   always_comb begin
      stat.clr_last     = clr_cnt_ff == (RW + 1)'(DEPTH - 1);
      stat.req_free     = req_opcode;
      stat.a_empty      = head_ff == '0;
      stat.a_more       = rd_data > cur_ff;
      stat.a_found      = found_ff;
      stat.a_split      = rest > NODE_W;
      stat.f_hdr_bad    = blk_calc < HDR_W;
      stat.f_size_bad   = rd_data < NODE_W || rd_data > ARENA_W || blk_ff > ARENA_W - rd_data;
      stat.f_walk_go    = cur_ff != '0 && cur_ff < blk_ff;
      stat.f_wn_stop    = rd_data <= cur_ff;
      stat.f_has_prev   = prev_ff != '0;
      stat.f_prev_bad   = prev_ff + rd_data > blk_ff;
      stat.f_cur_bad    = cur_ff != '0 && cur_ff < end_ff;
      stat.f_cur_merge  = cur_ff != '0 && cur_ff == end_ff;
      stat.f_prev_merge = prev_ff != '0 && prev_ff + psz_ff == blk_ff;
   end

   always_comb begin
      head_in     = head_ff;
      total_in    = total_ff;
      amount_in   = amount_ff;
      location_in = location_ff;
      req_in      = req_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      best_in     = best_ff;
      bestprev_in = bestprev_ff;
      bestsz_in   = bestsz_ff;
      bestnext_in = bestnext_ff;
      found_in    = found_ff;
      sz_in       = sz_ff;
      blk_in      = blk_ff;
      end_in      = end_ff;
      psz_in      = psz_ff;
      nsz_in      = nsz_ff;
      nnext_in    = nnext_ff;
      link_in     = link_ff;
      grant_in    = grant_ff;
      clr_cnt_in  = clr_cnt_ff;
      rd_addr     = cur_ff;
      wr_req      = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      clr_en      = 1'b0;
      case (cmd.op)
         bffla_pkg::OP_CLR: begin
            clr_en     = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         bffla_pkg::OP_INIT0: begin
            wr_req  = 1'b1;
            wr_addr = '0;
            wr_data = ARENA_W;
         end
         bffla_pkg::OP_INIT1: begin
            wr_req  = 1'b1;
            wr_addr = WORD_W;
            wr_data = HDR_W;
         end
         bffla_pkg::OP_INIT2: begin
            wr_req  = 1'b1;
            wr_addr = HDR_W;
            wr_data = ARENA_W - HDR_W;
         end
         bffla_pkg::OP_LOAD: begin
            amount_in   = req_amount;
            location_in = req_location;
            grant_in    = '0;
         end
         bffla_pkg::OP_ASTART: begin
            req_in   = (amt4 < NODE_W) ? NODE_W : amt4;
            cur_in   = head_ff;
            prev_in  = '0;
            found_in = 1'b0;
         end
         bffla_pkg::OP_ARS: begin
            rd_addr = cur_ff;
         end
         bffla_pkg::OP_ARN: begin
            sz_in   = rd_data;
            rd_addr = cur_ff + WORD_W;
         end
         bffla_pkg::OP_AEV: begin
            if (sz_ff >= req_ff && (!found_ff || sz_ff < bestsz_ff)) begin
               best_in     = cur_ff;
               bestprev_in = prev_ff;
               bestsz_in   = sz_ff;
               bestnext_in = rd_data;
               found_in    = 1'b1;
            end
            prev_in = cur_ff;
            cur_in  = rd_data;
         end
         bffla_pkg::OP_AEND: begin
            if (rest > NODE_W) begin
               link_in = best_ff + req_ff;
            end else begin
               req_in  = bestsz_ff;
               link_in = bestnext_ff;
            end
         end
         bffla_pkg::OP_ASPL1: begin
            wr_req  = 1'b1;
            wr_addr = link_ff;
            wr_data = rest;
         end
         bffla_pkg::OP_ASPL2: begin
            wr_req  = 1'b1;
            wr_addr = link_ff + WORD_W;
            wr_data = bestnext_ff;
         end
         bffla_pkg::OP_ALINK: begin
            wr_req  = 1'b1;
            wr_data = link_ff;
            if (bestprev_ff != '0) begin
               wr_addr = bestprev_ff + WORD_W;
            end else begin
               wr_addr = WORD_W;
               head_in = link_ff;
            end
         end
         bffla_pkg::OP_AHDR: begin
            wr_req   = 1'b1;
            wr_addr  = best_ff;
            wr_data  = req_ff;
            total_in = total_ff - req_ff;
            grant_in = grant_full[bffla_pkg::LOC_W-1:0];
         end
         bffla_pkg::OP_FSTART: begin
            blk_in  = blk_calc;
            rd_addr = blk_calc;
         end
         bffla_pkg::OP_FSIZE: begin
            sz_in   = rd_data;
            end_in  = blk_ff + rd_data;
            cur_in  = head_ff;
            prev_in = '0;
            psz_in  = '0;
         end
         bffla_pkg::OP_FWALK: begin
            rd_addr = cur_ff + WORD_W;
         end
         bffla_pkg::OP_FWN: begin
            prev_in = cur_ff;
            cur_in  = (rd_data <= cur_ff) ? '0 : rd_data;
         end
         bffla_pkg::OP_FPREV: begin
            rd_addr = prev_ff;
         end
         bffla_pkg::OP_FPCHK: begin
            psz_in = rd_data;
         end
         bffla_pkg::OP_FCUR: begin
            rd_addr  = cur_ff;
            nsz_in   = sz_ff;
            nnext_in = cur_ff;
         end
         bffla_pkg::OP_FN1: begin
            nsz_in  = sz_ff + rd_data;
            rd_addr = cur_ff + WORD_W;
         end
         bffla_pkg::OP_FN2: begin
            nnext_in = rd_data;
         end
         bffla_pkg::OP_FM1: begin
            wr_req  = 1'b1;
            wr_addr = prev_ff;
            wr_data = psz_ff + nsz_ff;
         end
         bffla_pkg::OP_FM2: begin
            wr_req   = 1'b1;
            wr_addr  = prev_ff + WORD_W;
            wr_data  = nnext_ff;
            total_in = total_ff + sz_ff;
         end
         bffla_pkg::OP_FB1: begin
            wr_req  = 1'b1;
            wr_addr = blk_ff;
            wr_data = nsz_ff;
         end
         bffla_pkg::OP_FB2: begin
            wr_req  = 1'b1;
            wr_addr = blk_ff + WORD_W;
            wr_data = nnext_ff;
         end
         bffla_pkg::OP_FB3: begin
            wr_req   = 1'b1;
            wr_data  = blk_ff;
            total_in = total_ff + sz_ff;
            if (prev_ff != '0) begin
               wr_addr = prev_ff + WORD_W;
            end else begin
               wr_addr = WORD_W;
               head_in = blk_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= HDR_W;
         total_ff      <= ARENA_W - HDR_W;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         total_ff      <= total_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_strobe_ff <= cmd.op == bffla_pkg::OP_RESP;
      end
      amount_ff   <= amount_in;
      location_ff <= location_in;
      req_ff      <= req_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      best_ff     <= best_in;
      bestprev_ff <= bestprev_in;
      bestsz_ff   <= bestsz_in;
      bestnext_ff <= bestnext_in;
      found_ff    <= found_in;
      sz_ff       <= sz_in;
      blk_ff      <= blk_in;
      end_ff      <= end_in;
      psz_ff      <= psz_in;
      nsz_ff      <= nsz_in;
      nnext_ff    <= nnext_in;
      link_ff     <= link_in;
      grant_ff    <= grant_in;
      rd_lane_ff  <= rd_addr[1:0];
      rd_oob_ff   <= rd_addr > LAST_W;
      if (cmd.op == bffla_pkg::OP_RESP) begin
         rsp_ok_ff    <= cmd.ok;
         rsp_grant_ff <= cmd.ok ? grant_ff : '0;
         rsp_free_ff  <= total_ff[bffla_pkg::FREE_W-1:0];
      end
   end

   // four byte lanes so an unaligned word moves in a single access
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [1:0]    wk, rk;
      logic [DW-1:0] wsum, rsum;
      logic          we;
      logic [RW-1:0] wrow;
      logic [7:0]    wbyte;

      assign wk    = 2'(b) - wr_addr[1:0];
      assign rk    = 2'(b) - rd_addr[1:0];
      assign wsum  = wr_addr + DW'(wk);
      assign rsum  = rd_addr + DW'(rk);
      assign we    = clr_en || (wr_req && wr_addr <= LAST_W);
      assign wrow  = clr_en ? clr_cnt_ff[RW-1:0] : wsum[RW+1:2];
      assign wbyte = clr_en ? 8'h00 : wr_data[8*wk +: 8];

      bffla_ram #(
         .WIDTH (8),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (wrow),
         .wr_data (wbyte),
         .rd_addr (rsum[RW+1:2]),
         .rd_data (bank_q[b])
      );
   end

   always_comb begin
      logic [1:0] sel;
      rd_data = '0;
      for (int k = 0; k < 4; k++) begin
         sel = rd_lane_ff + 2'(k);
         rd_data[8*k +: 8] = bank_q[sel];
      end
      if (rd_oob_ff) rd_data = '0;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_granted_offset = rsp_grant_ff;
   assign rsp_free_bytes     = rsp_free_ff;

endmodule

### rtl/core/best_fit_free_list_allocator.sv
`timescale 1ns / 1ps
// best_fit_free_list_allocator: top level, controller plus datapath
// depends on bffla_pkg, bffla_ctrl, bffla_dp
//
// channel   ports                                  transfer
// request   start, busy, req_opcode/amount/location  start && !busy
// response  rsp_strobe, rsp_ok/granted_offset/free_bytes  rsp_strobe, one cycle
//
// allocate: walks every free node, keeps the best fit, splits it if large enough;
// free: walks the nodes below the block, then merges it with adjacent free blocks
// or links it in; after reset a clearing pass of the arena holds busy high
// the response cannot be stalled; it shows in the first cycle with busy low

module best_fit_free_list_allocator #(
   parameter int ARENA_BYTES = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_opcode,
   input  logic [bffla_pkg::AMOUNT_W-1:0] req_amount,
   input  logic [bffla_pkg::LOC_W-1:0]    req_location,
   output logic                           rsp_strobe,
   output logic                           rsp_ok,
   output logic [bffla_pkg::LOC_W-1:0]    rsp_granted_offset,
   output logic [bffla_pkg::FREE_W-1:0]   rsp_free_bytes
);

   bffla_pkg::dp_cmd_type  cmd;
   bffla_pkg::dp_stat_type stat;

   bffla_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bffla_dp #(
      .ARENA_BYTES (ARENA_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_opcode         (req_opcode),
      .req_amount         (req_amount),
      .req_location       (req_location),
      .rsp_strobe         (rsp_strobe),
      .rsp_ok             (rsp_ok),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_free_bytes     (rsp_free_bytes)
   );

endmodule

### rtl/core/bffla_checker.sv
`timescale 1ns / 1ps
// bffla_checker: port-level assertions of the allocator and their bind
// depends on best_fit_free_list_allocator

module bffla_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_ok,
   input logic [15:0] rsp_granted_offset,
   input logic [16:0] rsp_free_bytes
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back to back responses");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> rsp_granted_offset == 16'd0)
      else $error("failed item carries an offset");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without work");

   a_free_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_strobe && !$past(reset) && !$past(rsp_strobe, 2)) |-> $stable(rsp_free_bytes))
      else $error("free byte count moved without a response");

endmodule

bind best_fit_free_list_allocator bffla_checker u_bffla_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_ok             (rsp_ok),
   .rsp_granted_offset (rsp_granted_offset),
   .rsp_free_bytes     (rsp_free_bytes)
);
